@@ sv/assert_macros.svh @@
// assert_macros.svh: assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ sv/jew_pkg.sv @@
// jew_pkg: beat types, command and kind codes, and character constants
// for the JSON event writer. No dependencies.
package jew_pkg;

   typedef enum logic [1:0] {
      CMD_START      = 2'd0,
      CMD_END        = 2'd1,
      CMD_DOUBLE_END = 2'd2,
      CMD_BYTE       = 2'd3
   } cmd_type;

   localparam logic [2:0] KIND_OBJECT  = 3'd0;
   localparam logic [2:0] KIND_ARRAY   = 3'd1;
   localparam logic [2:0] KIND_STRING  = 3'd2;
   localparam logic [2:0] KIND_NUMBER  = 3'd3;
   localparam logic [2:0] KIND_LITERAL = 3'd4;

   localparam logic [1:0] CTX_NONE   = 2'd0;
   localparam logic [1:0] CTX_VALUE  = 2'd1;
   localparam logic [1:0] CTX_NAME   = 2'd2;
   localparam logic [1:0] CTX_ELEM   = 2'd3;

   localparam logic [2:0] PFX_NONE         = 3'd0;
   localparam logic [2:0] PFX_COLON        = 3'd1;
   localparam logic [2:0] PFX_OBJ_START    = 3'd2;
   localparam logic [2:0] PFX_MEMBER_COMMA = 3'd3;
   localparam logic [2:0] PFX_ARR_START    = 3'd4;
   localparam logic [2:0] PFX_ARR_COMMA    = 3'd5;
   localparam logic [2:0] PFX_OBJ_END      = 3'd6;
   localparam logic [2:0] PFX_ARR_END      = 3'd7;

   localparam logic [2:0] MAX_BYTES = 3'd6;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   localparam logic [7:0] CTL_BS = 8'h08;
   localparam logic [7:0] CTL_TAB = 8'h09;
   localparam logic [7:0] CTL_LF = 8'h0A;
   localparam logic [7:0] CTL_FF = 8'h0C;
   localparam logic [7:0] CTL_CR = 8'h0D;

   typedef struct packed {
      cmd_type    cmd;
      logic [2:0] value_kind;
      logic [1:0] context_req;
      logic       first_in_group;
      logic       has_byte;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  prefix_code;
      logic [7:0]  out_depth;
      logic [2:0]  byte_count;
      logic [47:0] text_bytes;
   } rsp_item_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      if (n < 4'd10) begin
         return CH_ZERO + {4'h0, n};
      end
      return CH_LOWER_A + {4'h0, n} - 8'd10;
   endfunction

endpackage

@@ sv/jew_encode.sv @@
// jew_encode: combinational event encoder; one result beat plus next
// depth and kind from one event and the current state. Uses jew_pkg.
module jew_encode #(
   parameter int DEPTH_WIDTH = 8
) (
   input  jew_pkg::req_item_type   item,
   input  logic [DEPTH_WIDTH-1:0]  depth,
   input  logic [2:0]              kind,
   output jew_pkg::rsp_item_type   rsp,
   output logic [DEPTH_WIDTH-1:0]  depth_next,
   output logic [2:0]              kind_next
);
   import jew_pkg::*;

   localparam logic [DEPTH_WIDTH-1:0] DEPTH_ONE = DEPTH_WIDTH'(1);

   logic                   is_container;
   logic                   cur_container;
   logic [DEPTH_WIDTH-1:0] depth_after_inner;
   logic [DEPTH_WIDTH-1:0] end_depth;
   logic [7:0]             head_byte;
   logic [2:0]             start_prefix;
   logic [7:0]             b;

   assign is_container  = (item.value_kind == KIND_OBJECT) || (item.value_kind == KIND_ARRAY);
   assign cur_container = (kind == KIND_OBJECT) || (kind == KIND_ARRAY);
   assign head_byte     = item.has_byte ? item.data_byte : 8'h00;
   assign b             = item.data_byte;

   // double end: inner end closes the current kind first
   assign depth_after_inner = (cur_container && depth != '0) ? depth - DEPTH_ONE : depth;
   // depth the outer end works from
   assign end_depth = (item.cmd == CMD_DOUBLE_END) ? depth_after_inner : depth;

   always_comb begin
      case (item.context_req)
         CTX_VALUE: start_prefix = PFX_COLON;
         CTX_NAME:  start_prefix = item.first_in_group ? PFX_OBJ_START : PFX_MEMBER_COMMA;
         CTX_ELEM:  start_prefix = item.first_in_group ? PFX_ARR_START : PFX_ARR_COMMA;
         default:   start_prefix = PFX_NONE;
      endcase
   end

   always_comb begin
      rsp        = '0;
      depth_next = depth;
      kind_next  = kind;
      unique case (item.cmd)
         CMD_START: begin
            kind_next       = item.value_kind;
            rsp.prefix_code = start_prefix;
            rsp.out_depth   = 8'(depth);
            rsp.byte_count  = 3'd1;
            if (is_container) begin
               if (depth != '1) begin
                  depth_next = depth + DEPTH_ONE;
               end
               rsp.text_bytes[7:0] = (item.value_kind == KIND_OBJECT) ? CH_LBRACE : CH_LBRACKET;
            end else if (item.value_kind == KIND_STRING) begin
               rsp.text_bytes[7:0] = CH_QUOTE;
            end else begin
               rsp.text_bytes[7:0] = head_byte;
            end
         end
         CMD_END, CMD_DOUBLE_END: begin
            if (is_container) begin
               depth_next = (end_depth != '0) ? end_depth - DEPTH_ONE : end_depth;
               rsp.prefix_code = (item.value_kind == KIND_OBJECT) ? PFX_OBJ_END : PFX_ARR_END;
               rsp.out_depth   = 8'(depth_next);
               rsp.byte_count  = 3'd1;
               rsp.text_bytes[7:0] = (item.value_kind == KIND_OBJECT) ? CH_RBRACE : CH_RBRACKET;
            end else begin
               depth_next = end_depth;
               if (item.value_kind == KIND_STRING) begin
                  rsp.byte_count      = 3'd1;
                  rsp.text_bytes[7:0] = CH_QUOTE;
               end else if (item.cmd == CMD_END && head_byte != 8'h00) begin
                  rsp.byte_count      = 3'd1;
                  rsp.text_bytes[7:0] = head_byte;
               end
            end
         end
         CMD_BYTE: begin
            rsp.byte_count      = 3'd1;
            rsp.text_bytes[7:0] = b;
            if (kind == KIND_STRING) begin
               case (b)
                  CH_QUOTE, CH_BACKSLASH: begin
                     rsp.byte_count       = 3'd2;
                     rsp.text_bytes[15:0] = {b, CH_BACKSLASH};
                  end
                  CTL_BS: begin
                     rsp.byte_count       = 3'd2;
                     rsp.text_bytes[15:0] = {CH_B, CH_BACKSLASH};
                  end
                  CTL_FF: begin
                     rsp.byte_count       = 3'd2;
                     rsp.text_bytes[15:0] = {CH_F, CH_BACKSLASH};
                  end
                  CTL_LF: begin
                     rsp.byte_count       = 3'd2;
                     rsp.text_bytes[15:0] = {CH_N, CH_BACKSLASH};
                  end
                  CTL_CR: begin
                     rsp.byte_count       = 3'd2;
                     rsp.text_bytes[15:0] = {CH_R, CH_BACKSLASH};
                  end
                  CTL_TAB: begin
                     rsp.byte_count       = 3'd2;
                     rsp.text_bytes[15:0] = {CH_T, CH_BACKSLASH};
                  end
                  default: begin
                     if (b < CH_SPACE) begin
                        // \u00XX form carries the current depth
                        rsp.out_depth  = 8'(depth);
                        rsp.byte_count = MAX_BYTES;
                        rsp.text_bytes = {hex_digit(b[3:0]), hex_digit(b[7:4]),
                                          CH_ZERO, CH_ZERO, CH_U, CH_BACKSLASH};
                     end
                  end
               endcase
            end
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

endmodule

@@ sv/json_event_writer.sv @@
// json_event_writer: top level of the JSON event writer; input register,
// encoder, result register. Uses jew_pkg and jew_encode.
//
//   channel | ports                         | beat
//   --------+-------------------------------+------------------------------
//   request | req_valid, req_stall, req_item | one writer event
//   result  | rsp_valid, rsp_stall, rsp_item | prefix, depth, up to 6 bytes
//
// One event per clock sustained while rsp_stall is low; every event gives
// exactly one result beat. Path: request register, encoder, result register.
// The depth/kind state updates as an event leaves the request register, so
// back-to-back events see each other's effects with no bubble.
// Reset (synchronous, active high) clears both valid flags, depth and kind.
// req_stall rises only when both registers are full and rsp_stall is high.
module json_event_writer #(
   parameter int DEPTH_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  jew_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output jew_pkg::rsp_item_type rsp_item
);
   import jew_pkg::*;

   // request register
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   // result register
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   // writer state
   logic [DEPTH_WIDTH-1:0] depth_ff, depth_in;
   logic [2:0]             kind_ff, kind_in;

   rsp_item_type           enc_rsp;
   logic [DEPTH_WIDTH-1:0] enc_depth;
   logic [2:0]             enc_kind;
   logic                   advance;
   logic                   fire;

   jew_encode #(
      .DEPTH_WIDTH(DEPTH_WIDTH)
   ) u_encode (
      .item       (in_item_ff),
      .depth      (depth_ff),
      .kind       (kind_ff),
      .rsp        (enc_rsp),
      .depth_next (enc_depth),
      .kind_next  (enc_kind)
   );

   // result register frees up when empty or when its beat is taken
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      depth_in     = depth_ff;
      kind_in      = kind_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            out_item_in = enc_rsp;
         end
      end
      if (fire) begin
         depth_in = enc_depth;
         kind_in  = enc_kind;
      end
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         depth_ff     <= '0;
         kind_ff      <= KIND_OBJECT;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         depth_ff     <= depth_in;
         kind_ff      <= kind_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

@@ sv/jew_checker.sv @@
// jew_checker: port-level checks for json_event_writer, bound to the top.
// Uses jew_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jew_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input jew_pkg::rsp_item_type rsp_item
);
   import jew_pkg::*;

   logic req_beat;
   logic rsp_beat;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   // held result beat stays put
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

   // backpressure only passes through from a stalled, full result side
   `ASSERT_IMPLY(a_stall_source, clock, reset, req_stall, rsp_valid && rsp_stall)

   // no beat appears from nothing: quiet input and drained output stay empty
   `ASSERT_IMPLY(a_drained, clock, reset,
      !$past(req_beat, 1) && !$past(req_beat, 2) && $past(rsp_beat, 1) && !$past(rsp_stall, 2),
      !rsp_valid)

   // result beats never exceed six bytes
   `ASSERT_IMPLY(a_count, clock, reset, rsp_valid, rsp_item.byte_count <= MAX_BYTES)

endmodule

bind json_event_writer jew_checker u_jew_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
